// ----- hw/rtl/stun_binding_response_parser_defines.svh -----
// Assertion macros shared by the STUN binding response parser RTL.
// Included by files that carry concurrent checks; expects aclk and aresetn in scope.
`ifndef STUN_BINDING_RESPONSE_PARSER_DEFINES_SVH
`define STUN_BINDING_RESPONSE_PARSER_DEFINES_SVH

// check sampled on aclk, masked while in reset
`define SBRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check sampled on aclk, also active across reset
`define SBRP_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/sbrp_pkg.sv -----
// Types and constants for the STUN binding response parser.
// No dependencies; used by sbrp_core and stun_binding_response_parser.
`default_nettype none

package sbrp_pkg;

    localparam logic [31:0] MAGIC_COOKIE    = 32'h2112_A442;
    localparam logic [15:0] TYPE_BINDING_OK = 16'h0101;
    localparam logic [13:0] ATTR_MAPPED     = 14'h0001;
    localparam logic [13:0] ATTR_XOR_MAPPED = 14'h0020;
    localparam logic [7:0]  FAMILY_IPV4     = 8'h01;
    localparam logic [15:0] ADDR_LEN        = 16'd8;

    localparam logic [1:0] CFG_TXID_UPPER = 2'd0;
    localparam logic [1:0] CFG_TXID_LOWER = 2'd1;

    typedef enum logic [2:0] {
        PH_TYPE   = 3'd0,
        PH_LEN    = 3'd1,
        PH_COOKIE = 3'd2,
        PH_TXID   = 3'd3,
        PH_HDR    = 3'd4,
        PH_ADDR   = 3'd5,
        PH_SKIP   = 3'd6,
        PH_ERR    = 3'd7
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_BAD_TYPE    = 3'd1,
        ST_BAD_COOKIE  = 3'd2,
        ST_BAD_TXID    = 3'd3,
        ST_BAD_HDR     = 3'd4,
        ST_BAD_ADDRLEN = 3'd5,
        ST_BAD_FAMILY  = 3'd6,
        ST_TRUNC_ADDR  = 3'd7
    } status_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  byte_count;
        logic [31:0] field_shift;
        logic        attr_xor;
        logic [16:0] skip_remaining;
        logic [31:0] addr_ip;
        logic [15:0] addr_port;
        logic        found;
        status_t     error_code;
    } parse_state_t;

    typedef struct packed {
        status_t     status;
        logic        address_found;
        logic [31:0] public_ip;
        logic [15:0] public_port;
    } parse_result_t;

    localparam parse_state_t PARSE_STATE_RESET = '{
        phase:          PH_TYPE,
        byte_count:     4'd0,
        field_shift:    32'd0,
        attr_xor:       1'b0,
        skip_remaining: 17'd0,
        addr_ip:        32'd0,
        addr_port:      16'd0,
        found:          1'b0,
        error_code:     ST_OK
    };

endpackage

`default_nettype wire

// ----- hw/rtl/sbrp_core.sv -----
// Per-byte next-state and end-of-packet result logic of the STUN response parser.
// Combinational; uses sbrp_pkg.
`default_nettype none

module sbrp_core (
    input  wire  sbrp_pkg::parse_state_t  cur,
    input  wire  logic [95:0]             txid,
    input  wire  logic [7:0]              data_byte,
    output sbrp_pkg::parse_state_t        nxt,
    output sbrp_pkg::parse_result_t       res
);

    logic [31:0] shifted;
    logic [3:0]  count_inc;
    logic [13:0] kind;
    logic [15:0] size;
    logic [1:0]  pad;
    logic [16:0] skip_len;
    logic [3:0]  txid_sel;
    logic [7:0]  txid_byte;
    logic [31:0] ip_raw;
    sbrp_pkg::status_t status;

    assign shifted   = {cur.field_shift[23:0], data_byte};
    assign count_inc = cur.byte_count + 4'd1;
    assign kind      = shifted[29:16];
    assign size      = shifted[15:0];
    assign pad       = 2'(~size[1:0] + 2'd1);
    assign skip_len  = {1'b0, size} + {15'd0, pad};
    assign txid_sel  = 4'd11 - cur.byte_count;
    assign txid_byte = txid[{txid_sel, 3'b000} +: 8];
    assign ip_raw    = (cur.byte_count >= 4'd4) ? shifted : cur.field_shift;

    always_comb begin
        nxt = cur;
        case (cur.phase)
            sbrp_pkg::PH_TYPE: begin
                nxt.field_shift = shifted;
                nxt.byte_count  = count_inc;
                if (count_inc == 4'd2) begin
                    if (shifted[15:0] != sbrp_pkg::TYPE_BINDING_OK) begin
                        nxt.phase      = sbrp_pkg::PH_ERR;
                        nxt.error_code = sbrp_pkg::ST_BAD_TYPE;
                    end else begin
                        nxt.phase       = sbrp_pkg::PH_LEN;
                        nxt.byte_count  = 4'd0;
                        nxt.field_shift = 32'd0;
                    end
                end
            end
            sbrp_pkg::PH_LEN: begin
                nxt.byte_count = count_inc;
                if (count_inc == 4'd2) begin
                    nxt.phase      = sbrp_pkg::PH_COOKIE;
                    nxt.byte_count = 4'd0;
                end
            end
            sbrp_pkg::PH_COOKIE: begin
                nxt.field_shift = shifted;
                nxt.byte_count  = count_inc;
                if (count_inc == 4'd4) begin
                    if (shifted != sbrp_pkg::MAGIC_COOKIE) begin
                        nxt.phase      = sbrp_pkg::PH_ERR;
                        nxt.error_code = sbrp_pkg::ST_BAD_COOKIE;
                    end else begin
                        nxt.phase       = sbrp_pkg::PH_TXID;
                        nxt.byte_count  = 4'd0;
                        nxt.field_shift = 32'd0;
                    end
                end
            end
            sbrp_pkg::PH_TXID: begin
                if (data_byte != txid_byte) begin
                    nxt.phase      = sbrp_pkg::PH_ERR;
                    nxt.error_code = sbrp_pkg::ST_BAD_TXID;
                end else begin
                    nxt.byte_count = count_inc;
                    if (count_inc == 4'd12) begin
                        nxt.phase      = sbrp_pkg::PH_HDR;
                        nxt.byte_count = 4'd0;
                    end
                end
            end
            sbrp_pkg::PH_HDR: begin
                nxt.field_shift = shifted;
                nxt.byte_count  = count_inc;
                if (count_inc == 4'd4) begin
                    nxt.byte_count  = 4'd0;
                    nxt.field_shift = 32'd0;
                    nxt.attr_xor    = (kind == sbrp_pkg::ATTR_XOR_MAPPED);
                    if (kind == sbrp_pkg::ATTR_MAPPED || kind == sbrp_pkg::ATTR_XOR_MAPPED) begin
                        if (size != sbrp_pkg::ADDR_LEN) begin
                            nxt.phase      = sbrp_pkg::PH_ERR;
                            nxt.error_code = sbrp_pkg::ST_BAD_ADDRLEN;
                        end else begin
                            nxt.phase = sbrp_pkg::PH_ADDR;
                        end
                    end else begin
                        nxt.skip_remaining = skip_len;
                        if (skip_len != 17'd0) begin
                            nxt.phase = sbrp_pkg::PH_SKIP;
                        end
                    end
                end
            end
            sbrp_pkg::PH_ADDR: begin
                if (cur.byte_count == 4'd1 && data_byte != sbrp_pkg::FAMILY_IPV4) begin
                    nxt.phase      = sbrp_pkg::PH_ERR;
                    nxt.error_code = sbrp_pkg::ST_BAD_FAMILY;
                end else begin
                    if (cur.byte_count == 4'd2 || cur.byte_count == 4'd3) begin
                        nxt.addr_port = {cur.addr_port[7:0], data_byte};
                    end
                    if (cur.byte_count >= 4'd4) begin
                        nxt.field_shift = shifted;
                    end
                    nxt.byte_count = count_inc;
                    if (count_inc == 4'd8) begin
                        if (cur.attr_xor) begin
                            nxt.addr_ip   = ip_raw ^ sbrp_pkg::MAGIC_COOKIE;
                            nxt.addr_port = nxt.addr_port ^ sbrp_pkg::MAGIC_COOKIE[31:16];
                        end else begin
                            nxt.addr_ip = ip_raw;
                        end
                        nxt.found       = 1'b1;
                        nxt.phase       = sbrp_pkg::PH_HDR;
                        nxt.byte_count  = 4'd0;
                        nxt.field_shift = 32'd0;
                    end
                end
            end
            sbrp_pkg::PH_SKIP: begin
                nxt.skip_remaining = cur.skip_remaining - 17'd1;
                if (nxt.skip_remaining == 17'd0) begin
                    nxt.phase      = sbrp_pkg::PH_HDR;
                    nxt.byte_count = 4'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // status if this byte ends the packet
    always_comb begin
        case (nxt.phase)
            sbrp_pkg::PH_ERR:    status = nxt.error_code;
            sbrp_pkg::PH_TYPE:   status = sbrp_pkg::ST_BAD_TYPE;
            sbrp_pkg::PH_LEN:    status = sbrp_pkg::ST_BAD_COOKIE;
            sbrp_pkg::PH_COOKIE: status = sbrp_pkg::ST_BAD_COOKIE;
            sbrp_pkg::PH_TXID:   status = sbrp_pkg::ST_BAD_TXID;
            sbrp_pkg::PH_HDR:
                status = (nxt.byte_count != 4'd0) ? sbrp_pkg::ST_BAD_HDR : sbrp_pkg::ST_OK;
            sbrp_pkg::PH_ADDR:
                status = (nxt.byte_count < 4'd2) ? sbrp_pkg::ST_BAD_FAMILY
                                                 : sbrp_pkg::ST_TRUNC_ADDR;
            default:             status = sbrp_pkg::ST_OK;
        endcase
    end

    always_comb begin
        res.status = status;
        if (status == sbrp_pkg::ST_OK && nxt.found) begin
            res.address_found = 1'b1;
            res.public_ip     = nxt.addr_ip;
            res.public_port   = nxt.addr_port;
        end else begin
            res.address_found = 1'b0;
            res.public_ip     = 32'd0;
            res.public_port   = 16'd0;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/stun_binding_response_parser.sv -----
// The result appears on m_tvalid in the cycle after the last byte is accepted.
// Throughput: one byte per cycle; s_tready drops only while a result sits unaccepted.
// Each byte updates the parse state register through one level of logic (sbrp_core).
// Reset (aresetn low, synchronous) clears parse state, output valid and both
// transaction ID registers; a packet in progress is dropped.
// Top level of the STUN binding response parser; uses sbrp_pkg, sbrp_core and
// stun_binding_response_parser_defines.svh.
`default_nettype none

`include "stun_binding_response_parser_defines.svh"

module stun_binding_response_parser (
    input  wire  logic        aclk,
    input  wire  logic        aresetn,
    // configuration write port
    input  wire  logic        cfg_we,
    input  wire  logic [1:0]  cfg_index,
    input  wire  logic [63:0] cfg_wdata,
    // byte stream in
    input  wire  logic        s_tvalid,
    output logic              s_tready,
    input  wire  logic [7:0]  s_tdata,   // data_byte[7:0]
    input  wire  logic        s_tlast,   // last_byte
    // result out
    output logic              m_tvalid,
    input  wire  logic        m_tready,
    output logic [55:0]       m_tdata    // status[2:0], address_found[3],
                                         // public_ip[35:4], public_port[51:36], zero[55:52]
);

    logic [31:0] txid_upper_reg;
    logic [63:0] txid_lower_reg;
    sbrp_pkg::parse_state_t  state_reg;
    sbrp_pkg::parse_state_t  state_next;
    sbrp_pkg::parse_result_t result_next;
    sbrp_pkg::parse_result_t result_reg;
    logic m_valid_reg;
    logic s_accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    sbrp_core u_core (
        .cur       (state_reg),
        .txid      ({txid_upper_reg, txid_lower_reg}),
        .data_byte (s_tdata),
        .nxt       (state_next),
        .res       (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            txid_upper_reg <= 32'd0;
            txid_lower_reg <= 64'd0;
            state_reg      <= sbrp_pkg::PARSE_STATE_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == sbrp_pkg::CFG_TXID_UPPER) begin
                txid_upper_reg <= cfg_wdata[31:0];
            end
            if (cfg_we && cfg_index == sbrp_pkg::CFG_TXID_LOWER) begin
                txid_lower_reg <= cfg_wdata;
            end
            if (s_accept) begin
                state_reg <= s_tlast ? sbrp_pkg::PARSE_STATE_RESET : state_next;
            end
            if (s_accept && s_tlast) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && s_tlast) begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, result_reg.public_port, result_reg.public_ip,
                       result_reg.address_found, result_reg.status};

    `SBRP_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid_reg && state_reg.phase == sbrp_pkg::PH_TYPE, "reset did not clear parser")
    `SBRP_ASSERT(a_stall_blocks, m_valid_reg && !m_tready |-> !s_tready, "byte accepted while result stalled")
    `SBRP_ASSERT(a_last_restarts, s_accept && s_tlast |=> m_valid_reg && state_reg.phase == sbrp_pkg::PH_TYPE && state_reg.byte_count == 4'd0, "last byte did not emit result and restart")
    `SBRP_ASSERT(a_err_zero, m_valid_reg && result_reg.status != sbrp_pkg::ST_OK |-> !result_reg.address_found && result_reg.public_ip == 32'd0 && result_reg.public_port == 16'd0, "error result carries address")

endmodule

`default_nettype wire
